// File: rtl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 package
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

  localparam logic [31:0] TjLow  = 32'h79CC4519;
  localparam logic [31:0] TjHigh = 32'h7A879D8A;
  localparam logic [7:0]  PadByte = 8'h80;

  localparam logic [255:0] InitVector = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  // Item held in the queue between front and back
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
  } item_t;

  function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
  endfunction

endpackage

`default_nettype wire

// File: rtl/sm3_queue.sv
// ----------------------------------------------------------------------------
// SM3 input queue
// Two-entry queue between the input port and the hash core.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sm3_pkg::item_t push_item_i,
  output logic                full_o,
  output logic                valid_o,
  output sm3_pkg::item_t      item_o,
  input  wire logic           pop_i
);

  sm3_pkg::item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// File: rtl/sm3_core.sv
// ----------------------------------------------------------------------------
// SM3 core
// Byte packing, padding, 64-round compression with on-the-fly message
// expansion, and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  input  wire sm3_pkg::item_t item_i,
  output logic                item_pop_o,
  output logic                valid_o,
  input  wire logic           stall_i,
  output logic [31:0]         digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StByte = 6'b000010,
    StPad  = 6'b000100,
    StLen  = 6'b001000,
    StComp = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  state_e       state_q, state_d, ret_q;
  logic [31:0]  w_q [16];
  logic [255:0] cv_q;
  logic [255:0] v_q;
  logic [5:0]   fill_q;
  logic [63:0]  len_q;
  logic [2:0]   bidx_q;
  logic [5:0]   rnd_q;
  logic [2:0]   oidx_q;
  logic         out_v_q;
  logic [31:0]  out_w_q;
  logic [2:0]   out_i_q;

  logic [2:0]  cnt;
  logic [7:0]  byte_v;
  logic        put;
  logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tj, wn;
  logic        last_item;

  assign cnt       = (item_i.count > 3'd4) ? 3'd4 : item_i.count;
  assign last_item = item_i.last;

  // byte to be written this cycle
  always_comb begin
    put    = 1'b0;
    byte_v = 8'h00;
    case (state_q)
      StByte: begin
        put    = (bidx_q < cnt);
        byte_v = item_i.word[31 - 8*bidx_q -: 8];
      end
      StPad: begin
        put    = 1'b1;
        byte_v = (bidx_q == 3'd0) ? sm3_pkg::PadByte : 8'h00;
      end
      StLen: begin
        put    = 1'b1;
        byte_v = len_q[63 - 8*bidx_q -: 8];
      end
      default: ;
    endcase
  end

  // round datapath; w_q window holds W[j..j+15]
  always_comb begin
    a = v_q[255:224]; b = v_q[223:192]; c = v_q[191:160]; d = v_q[159:128];
    e = v_q[127:96];  f = v_q[95:64];   g = v_q[63:32];   h = v_q[31:0];
    tj  = (rnd_q < 6'd16) ? sm3_pkg::TjLow : sm3_pkg::TjHigh;
    a12 = sm3_pkg::rol(a, 5'd12);
    ss1 = sm3_pkg::rol(a12 + e + sm3_pkg::rol(tj, rnd_q[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_q < 6'd16) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
    end else begin
      ff = (a & b) | (a & c) | (b & c);
      gg = (e & f) | (~e & g);
    end
    tt1 = ff + d + ss2 + (w_q[0] ^ w_q[4]);
    tt2 = gg + h + ss1 + w_q[0];
    wn  = sm3_pkg::perm1(w_q[0] ^ w_q[7] ^ sm3_pkg::rol(w_q[13], 5'd15))
          ^ sm3_pkg::rol(w_q[3], 5'd7) ^ w_q[10];
  end

  assign item_pop_o    = (state_q == StByte) && !(bidx_q < cnt) &&
                         !((fill_q == 6'd63) && put);
  assign valid_o       = out_v_q;
  assign digest_word_o = out_w_q;
  assign word_index_o  = out_i_q;
  assign last_word_o   = (out_i_q == 3'd7);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (item_valid_i) state_d = StByte;
      StByte: begin
        if (put && fill_q == 6'd63) state_d = StComp;
        else if (!(bidx_q < cnt)) state_d = last_item ? StPad : StIdle;
      end
      StPad: begin
        if (fill_q == 6'd63) state_d = StComp;
        else if (fill_q == 6'd55) state_d = StLen;
      end
      StLen:  if (fill_q == 6'd63) state_d = StComp;
      StComp: if (rnd_q == 6'd63) state_d = ret_q;
      StOut:  if (oidx_q == 3'd7 && !(out_v_q && stall_i)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // block store and round window
  always_ff @(posedge clk_i) begin
    if (put) begin
      if (fill_q[1:0] == 2'd0) w_q[fill_q[5:2]] <= {byte_v, 24'h0};
      else w_q[fill_q[5:2]][31 - 8*fill_q[1:0] -: 8] <= byte_v;
    end
    if (state_q == StComp) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
    end
    if (state_q == StComp) begin
      v_q <= {tt1, a, sm3_pkg::rol(b, 5'd9), c,
              sm3_pkg::perm0(tt2), e, sm3_pkg::rol(f, 5'd19), g};
    end else begin
      v_q <= cv_q;
    end
  end

  // control, chain value and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      cv_q    <= sm3_pkg::InitVector;
      fill_q  <= 6'd0;
      len_q   <= 64'd0;
      bidx_q  <= 3'd0;
      rnd_q   <= 6'd0;
      oidx_q  <= 3'd0;
      out_v_q <= 1'b0;
      out_w_q <= 32'h0;
      out_i_q <= 3'd0;
    end else begin
      state_q <= state_d;
      if (put) fill_q <= fill_q + 6'd1;
      if (state_q == StByte && put) len_q <= len_q + 64'd8;
      // byte position counter
      case (state_q)
        StByte: bidx_q <= (put && fill_q == 6'd63) ? bidx_q + 3'd1
                          : (state_d == StByte ? bidx_q + 3'd1 : 3'd0);
        StPad:  bidx_q <= (state_d == StLen) ? 3'd0 : 3'd1;
        StLen:  bidx_q <= bidx_q + 3'd1;
        StComp: bidx_q <= (ret_q == StPad) ? 3'd1 : bidx_q;
        default: bidx_q <= 3'd0;
      endcase
      // return point after compression
      if (state_d == StComp && state_q != StComp) begin
        case (state_q)
          StByte:  ret_q <= StByte;
          StPad:   ret_q <= StPad;
          default: ret_q <= StOut;
        endcase
      end
      if (state_q == StComp) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          cv_q <= cv_q ^ {tt1, a, sm3_pkg::rol(b, 5'd9), c,
                          sm3_pkg::perm0(tt2), e, sm3_pkg::rol(f, 5'd19), g};
        end
      end
      // digest output
      if (out_v_q && !stall_i) out_v_q <= 1'b0;
      if (state_q == StOut && !(out_v_q && stall_i)) begin
        out_v_q <= 1'b1;
        out_w_q <= cv_q[255 - 32*oidx_q -: 32];
        out_i_q <= oidx_q;
        oidx_q  <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          cv_q   <= sm3_pkg::InitVector;
          fill_q <= 6'd0;
          len_q  <= 64'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streams 32-bit big-endian message words, emits the eight digest words.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  input    | valid_i / stall_o  | message_word_i, byte_count_i, is_last_i
//  output   | valid_o / stall_i  | digest_word_o, word_index_o, last_word_o
//
//  The packer takes each transaction through a start step, its bytes one at
//  a time and a release step; each full block adds a 64-round compression
//  at one round per cycle.
//  The final item adds padding bytes, one or two compressions and eight
//  digest words. A two-entry queue decouples the input from the core.
//  Reset restores the initial vector; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] message_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        is_last_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  sm3_pkg::item_t in_item, q_item;
  logic           q_full, q_valid, q_pop;

  assign in_item = '{word: message_word_i, count: byte_count_i, last: is_last_i};
  assign stall_o = q_full;

  sm3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (valid_i && !q_full),
    .push_item_i (in_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  sm3_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .item_pop_o    (q_pop),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams messages of random length and byte layout into the engine and
// checks every digest word against a built-in SM3 predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned StallLimit = 20000;

  // Idle behaviour of the two sides
  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_phase_e;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic        clk;
  logic        rst_n;
  logic        valid_in;
  logic        stall_out;
  logic [31:0] msg_word;
  logic [2:0]  msg_count;
  logic        msg_last;
  logic        valid_out;
  logic        stall_in;
  logic [31:0] dig_word;
  logic [2:0]  dig_index;
  logic        dig_last;

  msg_item_t    pending_items[$];
  digest_item_t expected_digests[$];
  idle_phase_e  idle_phase;
  logic         hold_off;
  int unsigned  quiet_cycles;
  bit           failed;
  bit           in_taken = 1'b0;  // input transaction taken at the last rising edge

  // Hash state of the predictor
  logic [31:0] hash_chain[8];
  logic [31:0] hash_block[16];
  logic [5:0]  hash_fill;
  logic [63:0] hash_bits;

  sm3_hash_engine i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .valid_i        (valid_in),
    .stall_o        (stall_out),
    .message_word_i (msg_word),
    .byte_count_i   (msg_count),
    .is_last_i      (msg_last),
    .valid_o        (valid_out),
    .stall_i        (stall_in),
    .digest_word_o  (dig_word),
    .word_index_o   (dig_index),
    .last_word_o    (dig_last)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    n = n % 32;
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic void hash_restart();
    hash_chain = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                   32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};
    foreach (hash_block[k]) hash_block[k] = '0;
    hash_fill = '0;
    hash_bits = '0;
  endfunction

  function automatic void hash_compress();
    logic [31:0] w[68];
    logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2, x;
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
    for (int j = 0; j < 16; j++) w[j] = hash_block[j];
    for (int j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15);
      w[j] = x ^ rotl(x, 15) ^ rotl(x, 23) ^ rotl(w[j-13], 7) ^ w[j-6];
    end
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
      a12 = rotl(a, 12);
      ss1 = rotl(a12 + e + rotl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rotl(b, 9); b = a; a = tt1;
      h = g; g = rotl(f, 19); f = e; e = tt2 ^ rotl(tt2, 9) ^ rotl(tt2, 17);
    end
    hash_chain[0] ^= a; hash_chain[1] ^= b; hash_chain[2] ^= c; hash_chain[3] ^= d;
    hash_chain[4] ^= e; hash_chain[5] ^= f; hash_chain[6] ^= g; hash_chain[7] ^= h;
  endfunction

  function automatic void hash_push_byte(logic [7:0] data);
    if (hash_fill[1:0] == 2'd0) hash_block[hash_fill[5:2]] = {data, 24'h0};
    else hash_block[hash_fill[5:2]] |= 32'(data) << ((3 - hash_fill[1:0]) * 8);
    hash_fill = hash_fill + 6'd1;
    if (hash_fill == 6'd0) hash_compress();
  endfunction

  // Absorb one accepted transaction; a final one queues the eight digest words
  function automatic void hash_absorb(msg_item_t item);
    int n;
    n = (item.count > 3'd4) ? 4 : int'(item.count);
    for (int k = 0; k < n; k++) begin
      hash_push_byte(item.word[31-8*k -: 8]);
      hash_bits += 64'd8;
    end
    if (!item.last) return;
    hash_push_byte(8'h80);
    while (hash_fill != 6'd56) hash_push_byte(8'h00);
    for (int s = 56; s >= 0; s -= 8) hash_push_byte(hash_bits[s +: 8]);
    for (int k = 0; k < 8; k++)
      expected_digests.push_back('{hash_chain[k], 3'(k), k == 7});
    hash_restart();
  endfunction

  function automatic bit rand_pct(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Driver: offers the oldest pending item at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        void'(pending_items.pop_front());
      end
      if (valid_in && !in_taken) begin
        // payload held while stalled
      end else if (pending_items.size() > 0 &&
                   !((idle_phase == IdleSender || idle_phase == IdleBoth) &&
                     rand_pct(57))) begin
        valid_in  <= 1'b1;
        msg_word  <= pending_items[0].word;
        msg_count <= pending_items[0].count;
        msg_last  <= pending_items[0].last;
      end else begin
        valid_in  <= 1'b0;
        msg_word  <= $urandom;
        msg_count <= 3'($urandom);
        msg_last  <= 1'($urandom);
      end
      stall_in <= hold_off ||
                  ((idle_phase == IdleReceiver || idle_phase == IdleBoth) && rand_pct(57));
    end
  end

  // Monitor: predicts at input acceptance, checks at output acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = valid_in && !stall_out;
      if (in_taken) begin
        hash_absorb('{msg_word, msg_count, msg_last});
      end
      if (valid_out && !stall_in) begin
        if (expected_digests.size() == 0) begin
          $display("%0t: digest word %h idx %0d last %0b with none expected",
                   $time, dig_word, dig_index, dig_last);
          failed = 1'b1;
        end else begin
          if (expected_digests[0] != {dig_word, dig_index, dig_last}) begin
            $display("%0t: expected word %h idx %0d last %0b, got %h idx %0d last %0b",
                     $time, expected_digests[0].word, expected_digests[0].index,
                     expected_digests[0].last, dig_word, dig_index, dig_last);
            failed = 1'b1;
          end
          void'(expected_digests.pop_front());
        end
      end
      if (in_taken || (valid_out && !stall_in)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Random message: mostly full words, sometimes short words mid-stream
  task automatic queue_message(int n_words);
    for (int k = 0; k < n_words; k++) begin
      pending_items.push_back('{$urandom, rand_pct(85) ? 3'd4 : 3'($urandom),
                                k == n_words - 1});
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || valid_in || expected_digests.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    valid_in    = 1'b0;
    stall_in    = 1'b0;
    msg_word    = '0;
    msg_count   = '0;
    msg_last    = 1'b0;
    hold_off    = 1'b0;
    idle_phase  = IdleNone;
    quiet_cycles = 0;
    failed      = 1'b0;
    hash_restart();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty message, single "abc", extremes, odd counts, padding edges
    pending_items.push_back('{32'h0, 3'd0, 1'b1});
    pending_items.push_back('{32'h61626300, 3'd3, 1'b1});
    pending_items.push_back('{32'hFFFFFFFF, 3'd4, 1'b0});
    pending_items.push_back('{32'hFFFFFFFF, 3'd7, 1'b0});
    pending_items.push_back('{32'h12345678, 3'd0, 1'b0});
    pending_items.push_back('{32'hA5A5A5A5, 3'd1, 1'b0});
    pending_items.push_back('{32'h5A5A5A5A, 3'd2, 1'b1});
    // 56 bytes then a last word of count 5, taken as four bytes: two final blocks
    for (int k = 0; k < 14; k++) pending_items.push_back('{$urandom, 3'd4, 1'b0});
    pending_items.push_back('{32'hFFFFFFFF, 3'd5, 1'b1});
    wait_drained();

    // Random phases with different idling
    for (int p = 0; p < 4; p++) begin
      idle_phase = idle_phase_e'(p);
      for (int m = 0; m < 5; m++) queue_message($urandom_range(6, 1));
      if (p == 1) queue_message(20);
      wait_drained();
    end

    // Long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    queue_message(2);
    queue_message(1);
    queue_message(3);
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
    wait_drained();

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sm3_hash_engine.f
rtl/sm3_pkg.sv
rtl/sm3_queue.sv
rtl/sm3_core.sv
rtl/sm3_hash_engine.sv
test/testbench.sv
